[sv/bgs_pkg.sv]
// Shared types, codes and helpers of the barrier gate sequencer.
package bgs_pkg;

  localparam int PHASE_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int DUR_W     = 16;
  localparam int BLINK_W   = 4;
  localparam int RELAY_W   = 6;

  // Relay bit positions inside the relay level vector.
  localparam int REL_MAIN  = 0;
  localparam int REL_OPEN  = 1;
  localparam int REL_OLIM  = 2;
  localparam int REL_SENS  = 3;
  localparam int REL_CLIM  = 4;
  localparam int REL_CLOSE = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_SETTLE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_WAIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_RECHECK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_SETTLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_COUNT   = 3'd7;

  // Phase codes as seen on the result channel.
  localparam logic [PHASE_W-1:0] PH_STARTUP    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd1;
  localparam logic [PHASE_W-1:0] PH_OPENSETTLE = 4'd2;
  localparam logic [PHASE_W-1:0] PH_OPENLIMIT  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_PASS       = 4'd4;
  localparam logic [PHASE_W-1:0] PH_PROBE      = 4'd5;
  localparam logic [PHASE_W-1:0] PH_RECHECK    = 4'd6;
  localparam logic [PHASE_W-1:0] PH_PRESETTLE  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_CLOSELIMIT = 4'd8;
  localparam logic [PHASE_W-1:0] PH_POSTSETTLE = 4'd9;
  localparam logic [PHASE_W-1:0] PH_BLINKLOW   = 4'd10;
  localparam logic [PHASE_W-1:0] PH_BLINKHIGH  = 4'd11;

  typedef enum logic [11:0] {
    ST_STARTUP    = 12'b0000_0000_0001,
    ST_IDLE       = 12'b0000_0000_0010,
    ST_OPENSETTLE = 12'b0000_0000_0100,
    ST_OPENLIMIT  = 12'b0000_0000_1000,
    ST_PASS       = 12'b0000_0001_0000,
    ST_PROBE      = 12'b0000_0010_0000,
    ST_RECHECK    = 12'b0000_0100_0000,
    ST_PRESETTLE  = 12'b0000_1000_0000,
    ST_CLOSELIMIT = 12'b0001_0000_0000,
    ST_POSTSETTLE = 12'b0010_0000_0000,
    ST_BLINKLOW   = 12'b0100_0000_0000,
    ST_BLINKHIGH  = 12'b1000_0000_0000
  } state_t;

  function automatic logic [PHASE_W-1:0] phase_of(state_t s);
    logic [PHASE_W-1:0] p;
    case (s)
      ST_STARTUP:    p = PH_STARTUP;
      ST_IDLE:       p = PH_IDLE;
      ST_OPENSETTLE: p = PH_OPENSETTLE;
      ST_OPENLIMIT:  p = PH_OPENLIMIT;
      ST_PASS:       p = PH_PASS;
      ST_PROBE:      p = PH_PROBE;
      ST_RECHECK:    p = PH_RECHECK;
      ST_PRESETTLE:  p = PH_PRESETTLE;
      ST_CLOSELIMIT: p = PH_CLOSELIMIT;
      ST_POSTSETTLE: p = PH_POSTSETTLE;
      ST_BLINKLOW:   p = PH_BLINKLOW;
      ST_BLINKHIGH:  p = PH_BLINKHIGH;
      default:       p = PH_STARTUP;
    endcase
    return p;
  endfunction

endpackage

[sv/bgs_if.sv]
// Handshake interfaces for the tick, result and configuration channels.
interface bgs_tick_if;
  logic valid;
  logic ready;
  logic access_request;
  logic open_limit;
  logic light_clear;
  logic close_limit;
  modport source (output valid, access_request, open_limit, light_clear, close_limit,
                  input ready);
  modport sink (input valid, access_request, open_limit, light_clear, close_limit,
                output ready);
endinterface

interface bgs_result_if;
  logic valid;
  logic ready;
  logic main_relay;
  logic open_relay;
  logic open_limit_relay;
  logic sensor_enable;
  logic close_limit_relay;
  logic close_relay;
  logic run_led;
  logic [bgs_pkg::PHASE_W-1:0] phase;
  modport source (output valid, main_relay, open_relay, open_limit_relay, sensor_enable,
                  close_limit_relay, close_relay, run_led, phase, input ready);
  modport sink (input valid, main_relay, open_relay, open_limit_relay, sensor_enable,
                close_limit_relay, close_relay, run_led, phase, output ready);
endinterface

interface bgs_cfg_if;
  logic valid;
  logic ready;
  logic [bgs_pkg::CFG_IDX_W-1:0] index;
  logic [bgs_pkg::DUR_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/barrier_gate_sequencer_unit.sv]
// Barrier gate sequencer: phase machine, shared phase timer and result register.
//
//  channel  dir  payload                                         accepted when
//  tick     in   access_request open_limit light_clear           valid && ready
//                close_limit
//  result   out  six relay levels, run_led, phase (4 bits)       valid && ready
//  cfg      in   index (3 bits), data (16 bits)                  valid && ready
//
// Each accepted tick item's result is loaded into the result register; one item per
// cycle is sustained while result.ready stays high.
// The timer compare and the phase update form the one logic stage per item.
// tick.ready drops only while a result is held and result.ready is low.
// Reset (rst, synchronous) restores register defaults, startup phase and LED on.
// cfg is always ready; a write takes effect on the next tick.
module barrier_gate_sequencer_unit #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  bgs_tick_if.sink       tick,
  bgs_result_if.source   result,
  bgs_cfg_if.sink        cfg
);

  localparam int LW = (TIMER_WIDTH > bgs_pkg::DUR_W) ? TIMER_WIDTH : bgs_pkg::DUR_W;
  localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

  // Configuration registers
  logic [bgs_pkg::DUR_W-1:0]   poll_period_ms, open_settle_ms, pass_wait_ms;
  logic [bgs_pkg::DUR_W-1:0]   probe_enable_ms, probe_recheck_ms, close_settle_ms;
  logic [bgs_pkg::DUR_W-1:0]   blink_half_ms;
  logic [bgs_pkg::BLINK_W-1:0] blink_count;

  // Sequencer state
  bgs_pkg::state_t               state, state_next;
  logic [TIMER_WIDTH-1:0]        tick_count, count_next;
  logic                          held, held_next;
  logic [bgs_pkg::BLINK_W-1:0]   blinks_done, blinks_next;
  logic [bgs_pkg::RELAY_W-1:0]   relays, relays_next;
  logic                          led, led_next;

  logic                          out_valid;
  logic                          in_fire;

  logic [bgs_pkg::DUR_W-1:0]     dur;
  logic                          pin;
  logic [LW-1:0]                 dur_ext, lim_clip;
  logic [TIMER_WIDTH-1:0]        lim, cnt_inc;
  logic                          tdone, held_eff, poll_hit;
  logic [bgs_pkg::BLINK_W-1:0]   blink_inc;

  assign cfg.ready  = 1'b1;
  assign tick.ready = !out_valid || result.ready;
  assign in_fire    = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_period_ms   <= 16'd500;
      open_settle_ms   <= 16'd1000;
      pass_wait_ms     <= 16'd6000;
      probe_enable_ms  <= 16'd20;
      probe_recheck_ms <= 16'd5000;
      close_settle_ms  <= 16'd1000;
      blink_half_ms    <= 16'd500;
      blink_count      <= 4'd4;
    end else if (cfg.valid) begin
      case (cfg.index)
        bgs_pkg::CFG_POLL_PERIOD:   poll_period_ms   <= cfg.data;
        bgs_pkg::CFG_OPEN_SETTLE:   open_settle_ms   <= cfg.data;
        bgs_pkg::CFG_PASS_WAIT:     pass_wait_ms     <= cfg.data;
        bgs_pkg::CFG_PROBE_ENABLE:  probe_enable_ms  <= cfg.data;
        bgs_pkg::CFG_PROBE_RECHECK: probe_recheck_ms <= cfg.data;
        bgs_pkg::CFG_CLOSE_SETTLE:  close_settle_ms  <= cfg.data;
        bgs_pkg::CFG_BLINK_HALF:    blink_half_ms    <= cfg.data;
        bgs_pkg::CFG_BLINK_COUNT:   blink_count      <= cfg.data[bgs_pkg::BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  // Pick the duration and the polled pin of the current phase.
  always_comb begin
    dur = poll_period_ms;
    pin = 1'b0;
    case (state)
      bgs_pkg::ST_STARTUP:    pin = tick.close_limit;
      bgs_pkg::ST_IDLE:       pin = tick.access_request;
      bgs_pkg::ST_OPENSETTLE: dur = open_settle_ms;
      bgs_pkg::ST_OPENLIMIT:  pin = tick.open_limit;
      bgs_pkg::ST_PASS:       dur = pass_wait_ms;
      bgs_pkg::ST_PROBE:      dur = probe_enable_ms;
      bgs_pkg::ST_RECHECK:    dur = probe_recheck_ms;
      bgs_pkg::ST_PRESETTLE:  dur = close_settle_ms;
      bgs_pkg::ST_CLOSELIMIT: pin = tick.close_limit;
      bgs_pkg::ST_POSTSETTLE: dur = close_settle_ms;
      bgs_pkg::ST_BLINKLOW:   dur = blink_half_ms;
      bgs_pkg::ST_BLINKHIGH:  dur = blink_half_ms;
      default: ;
    endcase
  end

  // Clip the duration to the timer range, and treat zero as one tick.
  assign dur_ext  = LW'(dur);
  assign lim_clip = (dur_ext > LW'(TMAX)) ? LW'(TMAX) : dur_ext;
  assign lim      = (lim_clip == '0) ? TIMER_WIDTH'(1) : TIMER_WIDTH'(lim_clip);
  assign cnt_inc  = (tick_count != TMAX) ? tick_count + TIMER_WIDTH'(1) : tick_count;
  assign tdone    = cnt_inc >= lim;
  assign held_eff = (tick_count == '0) ? pin : held;
  assign poll_hit = tdone && held_eff;
  assign blink_inc = blinks_done + bgs_pkg::BLINK_W'(1);

  always_comb begin
    state_next  = state;
    count_next  = tdone ? '0 : cnt_inc;
    held_next   = held;
    blinks_next = blinks_done;
    relays_next = relays;
    led_next    = led;
    case (state)
      bgs_pkg::ST_STARTUP: begin
        if (!relays[bgs_pkg::REL_CLOSE]) begin
          count_next = '0;
          if (tick.close_limit) begin
            relays_next[bgs_pkg::REL_MAIN] = 1'b1;
            state_next = bgs_pkg::ST_IDLE;
          end else begin
            relays_next[bgs_pkg::REL_CLIM]  = 1'b1;
            relays_next[bgs_pkg::REL_CLOSE] = 1'b1;
          end
        end else begin
          held_next = held_eff;
          if (poll_hit) begin
            relays_next[bgs_pkg::REL_CLIM]  = 1'b0;
            relays_next[bgs_pkg::REL_CLOSE] = 1'b0;
            relays_next[bgs_pkg::REL_MAIN]  = 1'b1;
            state_next = bgs_pkg::ST_IDLE;
          end
        end
      end
      bgs_pkg::ST_IDLE: begin
        held_next = held_eff;
        if (poll_hit) begin
          relays_next[bgs_pkg::REL_OPEN] = 1'b1;
          state_next = bgs_pkg::ST_OPENSETTLE;
        end
      end
      bgs_pkg::ST_OPENSETTLE: begin
        if (tdone) begin
          relays_next[bgs_pkg::REL_OLIM] = 1'b1;
          state_next = bgs_pkg::ST_OPENLIMIT;
        end
      end
      bgs_pkg::ST_OPENLIMIT: begin
        held_next = held_eff;
        if (poll_hit) begin
          relays_next[bgs_pkg::REL_OPEN] = 1'b0;
          relays_next[bgs_pkg::REL_OLIM] = 1'b0;
          state_next = bgs_pkg::ST_PASS;
        end
      end
      bgs_pkg::ST_PASS: begin
        if (tdone) begin
          relays_next[bgs_pkg::REL_SENS] = 1'b1;
          state_next = bgs_pkg::ST_PROBE;
        end
      end
      bgs_pkg::ST_PROBE: begin
        if (tdone) begin
          held_next = tick.light_clear;
          relays_next[bgs_pkg::REL_SENS] = 1'b0;
          state_next = bgs_pkg::ST_RECHECK;
        end
      end
      bgs_pkg::ST_RECHECK: begin
        if (tdone) begin
          if (held) begin
            state_next = bgs_pkg::ST_PRESETTLE;
          end else begin
            relays_next[bgs_pkg::REL_SENS] = 1'b1;
            state_next = bgs_pkg::ST_PROBE;
          end
        end
      end
      bgs_pkg::ST_PRESETTLE: begin
        if (tdone) begin
          relays_next[bgs_pkg::REL_CLOSE] = 1'b1;
          relays_next[bgs_pkg::REL_CLIM]  = 1'b1;
          state_next = bgs_pkg::ST_CLOSELIMIT;
        end
      end
      bgs_pkg::ST_CLOSELIMIT: begin
        held_next = held_eff;
        if (poll_hit) begin
          relays_next[bgs_pkg::REL_CLIM]  = 1'b0;
          relays_next[bgs_pkg::REL_CLOSE] = 1'b0;
          relays_next[bgs_pkg::REL_MAIN]  = 1'b0;
          state_next = bgs_pkg::ST_POSTSETTLE;
        end
      end
      bgs_pkg::ST_POSTSETTLE: begin
        if (tdone) begin
          blinks_next = '0;
          if (blink_count == '0) begin
            relays_next[bgs_pkg::REL_MAIN] = 1'b1;
            state_next = bgs_pkg::ST_IDLE;
          end else begin
            led_next   = 1'b0;
            state_next = bgs_pkg::ST_BLINKLOW;
          end
        end
      end
      bgs_pkg::ST_BLINKLOW: begin
        if (tdone) begin
          led_next   = 1'b1;
          state_next = bgs_pkg::ST_BLINKHIGH;
        end
      end
      bgs_pkg::ST_BLINKHIGH: begin
        if (tdone) begin
          blinks_next = blink_inc;
          if (blink_inc >= blink_count) begin
            relays_next[bgs_pkg::REL_MAIN] = 1'b1;
            state_next = bgs_pkg::ST_IDLE;
          end else begin
            led_next   = 1'b0;
            state_next = bgs_pkg::ST_BLINKLOW;
          end
        end
      end
      default: begin
        // Recover from a corrupted phase as after reset.
        state_next  = bgs_pkg::ST_STARTUP;
        count_next  = '0;
        held_next   = 1'b0;
        blinks_next = '0;
        relays_next = '0;
        led_next    = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bgs_pkg::ST_STARTUP;
      tick_count  <= '0;
      held        <= 1'b0;
      blinks_done <= '0;
      relays      <= '0;
      led         <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (in_fire) begin
        state       <= state_next;
        tick_count  <= count_next;
        held        <= held_next;
        blinks_done <= blinks_next;
        relays      <= relays_next;
        led         <= led_next;
        out_valid   <= 1'b1;
      end else if (result.ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  // Result register: load the levels after this item's update.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result.main_relay        <= relays_next[bgs_pkg::REL_MAIN];
      result.open_relay        <= relays_next[bgs_pkg::REL_OPEN];
      result.open_limit_relay  <= relays_next[bgs_pkg::REL_OLIM];
      result.sensor_enable     <= relays_next[bgs_pkg::REL_SENS];
      result.close_limit_relay <= relays_next[bgs_pkg::REL_CLIM];
      result.close_relay       <= relays_next[bgs_pkg::REL_CLOSE];
      result.run_led           <= led_next;
      result.phase             <= bgs_pkg::phase_of(state_next);
    end
  end

  assign result.valid = out_valid;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted tick item produced no result");

  a_no_drive_clash: assert property (@(posedge clk) disable iff (rst)
    !(relays[bgs_pkg::REL_OPEN] && relays[bgs_pkg::REL_CLOSE]))
    else $error("open and close relays driven together");

  a_sensor_in_probe: assert property (@(posedge clk) disable iff (rst)
    relays[bgs_pkg::REL_SENS] |-> (state == bgs_pkg::ST_PROBE))
    else $error("light sensor enabled outside the probe phase");

  a_main_off_phases: assert property (@(posedge clk) disable iff (rst)
    !relays[bgs_pkg::REL_MAIN] |-> (state == bgs_pkg::ST_STARTUP ||
      state == bgs_pkg::ST_POSTSETTLE || state == bgs_pkg::ST_BLINKLOW ||
      state == bgs_pkg::ST_BLINKHIGH))
    else $error("main relay off in an operating phase");
`endif

endmodule

[verif/tb_barrier_gate_sequencer_unit.sv]
// Self-checking testbench for the barrier gate sequencer: guided random ticks against a predictor.
module tb_barrier_gate_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMER_W = 16;
  localparam int SETTLE_CYCLES = 10;
  localparam int GAP_PCT = 16;

  typedef struct packed {
    logic access_request;
    logic open_limit;
    logic light_clear;
    logic close_limit;
  } tick_pins_t;

  typedef struct packed {
    logic main_relay;
    logic open_relay;
    logic open_limit_relay;
    logic sensor_enable;
    logic close_limit_relay;
    logic close_relay;
    logic run_led;
    logic [bgs_pkg::PHASE_W-1:0] phase;
  } gate_levels_t;

  typedef enum int {SET_SMALL, SET_MIN, SET_BLINKS, SET_MAX} gate_setting_t;

  // Tracks the gate sequence and holds the relay levels due for each accepted tick.
  class gate_scoreboard;
    localparam longint unsigned TICK_MAX = (64'd1 << TIMER_W) - 64'd1;

    logic [bgs_pkg::DUR_W-1:0]   poll_ms, open_settle_ms, pass_wait_ms, probe_enable_ms;
    logic [bgs_pkg::DUR_W-1:0]   probe_recheck_ms, close_settle_ms, blink_half_ms;
    logic [bgs_pkg::BLINK_W-1:0] blink_total;

    logic [bgs_pkg::PHASE_W-1:0] phase;
    longint unsigned             count;
    bit                          held;
    logic [bgs_pkg::BLINK_W-1:0] blinks_done;
    logic [bgs_pkg::RELAY_W-1:0] relays;
    bit                          led;

    gate_levels_t levels_due_q[$];
    int errors;

    function new();
      poll_ms = 16'd500;
      open_settle_ms = 16'd1000;
      pass_wait_ms = 16'd6000;
      probe_enable_ms = 16'd20;
      probe_recheck_ms = 16'd5000;
      close_settle_ms = 16'd1000;
      blink_half_ms = 16'd500;
      blink_total = 4'd4;
      errors = 0;
      restore();
    endfunction

    function void restore();
      phase = bgs_pkg::PH_STARTUP;
      count = 0;
      held = 0;
      blinks_done = '0;
      relays = '0;
      led = 1'b1;
    endfunction

    function void enter(logic [bgs_pkg::PHASE_W-1:0] p);
      phase = p;
      count = 0;
    endfunction

    function void go_idle();
      relays[bgs_pkg::REL_MAIN] = 1'b1;
      enter(bgs_pkg::PH_IDLE);
    endfunction

    // Count one tick; report and restart when the duration has run out.
    function bit timer_done(logic [bgs_pkg::DUR_W-1:0] dur);
      longint unsigned lim;
      lim = 64'(dur);
      if (lim > TICK_MAX) lim = TICK_MAX;
      if (lim == 0) lim = 1;
      if (count < TICK_MAX) count++;
      if (count >= lim) begin
        count = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Sample on the first tick of a period, pass at its end if the sample was high.
    function bit poll(bit pin);
      bit done;
      if (count == 0) held = pin;
      done = timer_done(poll_ms);
      return done && held;
    endfunction

    function void write_reg(logic [bgs_pkg::CFG_IDX_W-1:0] idx,
                            logic [bgs_pkg::DUR_W-1:0] data);
      case (idx)
        bgs_pkg::CFG_POLL_PERIOD:   poll_ms = data;
        bgs_pkg::CFG_OPEN_SETTLE:   open_settle_ms = data;
        bgs_pkg::CFG_PASS_WAIT:     pass_wait_ms = data;
        bgs_pkg::CFG_PROBE_ENABLE:  probe_enable_ms = data;
        bgs_pkg::CFG_PROBE_RECHECK: probe_recheck_ms = data;
        bgs_pkg::CFG_CLOSE_SETTLE:  close_settle_ms = data;
        bgs_pkg::CFG_BLINK_HALF:    blink_half_ms = data;
        bgs_pkg::CFG_BLINK_COUNT:   blink_total = data[bgs_pkg::BLINK_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(tick_pins_t p);
      gate_levels_t lv;
      case (phase)
        bgs_pkg::PH_STARTUP: begin
          if (!relays[bgs_pkg::REL_CLOSE]) begin
            relays[bgs_pkg::REL_CLIM] = 1'b1;
            if (p.close_limit) begin
              relays[bgs_pkg::REL_CLIM] = 1'b0;
              go_idle();
            end else begin
              relays[bgs_pkg::REL_CLOSE] = 1'b1;
              count = 0;
            end
          end else if (poll(p.close_limit)) begin
            relays[bgs_pkg::REL_CLIM] = 1'b0;
            relays[bgs_pkg::REL_CLOSE] = 1'b0;
            go_idle();
          end
        end
        bgs_pkg::PH_IDLE: begin
          if (poll(p.access_request)) begin
            relays[bgs_pkg::REL_OPEN] = 1'b1;
            enter(bgs_pkg::PH_OPENSETTLE);
          end
        end
        bgs_pkg::PH_OPENSETTLE: begin
          if (timer_done(open_settle_ms)) begin
            relays[bgs_pkg::REL_OLIM] = 1'b1;
            enter(bgs_pkg::PH_OPENLIMIT);
          end
        end
        bgs_pkg::PH_OPENLIMIT: begin
          if (poll(p.open_limit)) begin
            relays[bgs_pkg::REL_OPEN] = 1'b0;
            relays[bgs_pkg::REL_OLIM] = 1'b0;
            enter(bgs_pkg::PH_PASS);
          end
        end
        bgs_pkg::PH_PASS: begin
          if (timer_done(pass_wait_ms)) begin
            relays[bgs_pkg::REL_SENS] = 1'b1;
            enter(bgs_pkg::PH_PROBE);
          end
        end
        bgs_pkg::PH_PROBE: begin
          if (timer_done(probe_enable_ms)) begin
            held = p.light_clear;
            relays[bgs_pkg::REL_SENS] = 1'b0;
            enter(bgs_pkg::PH_RECHECK);
          end
        end
        bgs_pkg::PH_RECHECK: begin
          if (timer_done(probe_recheck_ms)) begin
            if (held) begin
              enter(bgs_pkg::PH_PRESETTLE);
            end else begin
              relays[bgs_pkg::REL_SENS] = 1'b1;
              enter(bgs_pkg::PH_PROBE);
            end
          end
        end
        bgs_pkg::PH_PRESETTLE: begin
          if (timer_done(close_settle_ms)) begin
            relays[bgs_pkg::REL_CLOSE] = 1'b1;
            relays[bgs_pkg::REL_CLIM] = 1'b1;
            enter(bgs_pkg::PH_CLOSELIMIT);
          end
        end
        bgs_pkg::PH_CLOSELIMIT: begin
          if (poll(p.close_limit)) begin
            relays[bgs_pkg::REL_CLIM] = 1'b0;
            relays[bgs_pkg::REL_CLOSE] = 1'b0;
            relays[bgs_pkg::REL_MAIN] = 1'b0;
            enter(bgs_pkg::PH_POSTSETTLE);
          end
        end
        bgs_pkg::PH_POSTSETTLE: begin
          if (timer_done(close_settle_ms)) begin
            blinks_done = '0;
            if (blink_total == '0) begin
              go_idle();
            end else begin
              led = 1'b0;
              enter(bgs_pkg::PH_BLINKLOW);
            end
          end
        end
        bgs_pkg::PH_BLINKLOW: begin
          if (timer_done(blink_half_ms)) begin
            led = 1'b1;
            enter(bgs_pkg::PH_BLINKHIGH);
          end
        end
        bgs_pkg::PH_BLINKHIGH: begin
          if (timer_done(blink_half_ms)) begin
            blinks_done = blinks_done + 4'd1;
            if (blinks_done >= blink_total) begin
              go_idle();
            end else begin
              led = 1'b0;
              enter(bgs_pkg::PH_BLINKLOW);
            end
          end
        end
        default: restore();
      endcase

      lv.main_relay        = relays[bgs_pkg::REL_MAIN];
      lv.open_relay        = relays[bgs_pkg::REL_OPEN];
      lv.open_limit_relay  = relays[bgs_pkg::REL_OLIM];
      lv.sensor_enable     = relays[bgs_pkg::REL_SENS];
      lv.close_limit_relay = relays[bgs_pkg::REL_CLIM];
      lv.close_relay       = relays[bgs_pkg::REL_CLOSE];
      lv.run_led           = led;
      lv.phase             = phase;
      levels_due_q.push_back(lv);
    endfunction

    function void fail_note(string msg);
      errors++;
      if (errors <= 10) $display("mismatch %0d: %s", errors, msg);
    endfunction

    function void check_result(gate_levels_t got);
      gate_levels_t want;
      if (levels_due_q.size() == 0) begin
        fail_note($sformatf("result with nothing expected: %p", got));
        return;
      end
      want = levels_due_q.pop_front();
      if (got !== want) fail_note($sformatf("expected %p, got %p", want, got));
    endfunction

    function int pending();
      return levels_due_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;

  bgs_tick_if   tick_ch();
  bgs_result_if res_ch();
  bgs_cfg_if    cfg_ch();

  gate_scoreboard sb;

  barrier_gate_sequencer_unit #(.TIMER_WIDTH(TIMER_W)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (tick_ch.valid && tick_ch.ready)
        sb.note_tick(tick_pins_t'({tick_ch.access_request, tick_ch.open_limit,
                                   tick_ch.light_clear, tick_ch.close_limit}));
      if (res_ch.valid && res_ch.ready)
        sb.check_result(gate_levels_t'({res_ch.main_relay, res_ch.open_relay,
                                        res_ch.open_limit_relay, res_ch.sensor_enable,
                                        res_ch.close_limit_relay, res_ch.close_relay,
                                        res_ch.run_led, res_ch.phase}));
      if (cfg_ch.valid && cfg_ch.ready)
        sb.write_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  // Stall the result side at random, except during the steady stretch.
  always @(negedge clk) begin
    res_ch.ready <= steady || ($urandom_range(0, 99) >= GAP_PCT);
  end

  // Favor the pin that lets the current phase move on; keep the rest random.
  function automatic tick_pins_t next_pins();
    tick_pins_t p;
    bit help;
    p = tick_pins_t'($urandom_range(0, 15));
    help = $urandom_range(0, 99) < 80;
    case (sb.phase)
      bgs_pkg::PH_STARTUP, bgs_pkg::PH_CLOSELIMIT: if (help) p.close_limit = 1'b1;
      bgs_pkg::PH_IDLE:                            if (help) p.access_request = 1'b1;
      bgs_pkg::PH_OPENLIMIT:                       if (help) p.open_limit = 1'b1;
      default: ;
    endcase
    return p;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_tick(tick_pins_t p);
    tick_ch.valid          <= 1'b1;
    tick_ch.access_request <= p.access_request;
    tick_ch.open_limit     <= p.open_limit;
    tick_ch.light_clear    <= p.light_clear;
    tick_ch.close_limit    <= p.close_limit;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_ticks(int n, bit guided);
    for (int i = 0; i < n; i++) begin
      while (!steady && $urandom_range(0, 99) < GAP_PCT) begin
        tick_ch.valid <= 1'b0;
        @(negedge clk);
      end
      if (guided) send_tick(next_pins());
      else send_tick(tick_pins_t'('1));
    end
    tick_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [bgs_pkg::CFG_IDX_W-1:0] idx,
                           logic [bgs_pkg::DUR_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_setting(gate_setting_t kind);
    logic [bgs_pkg::DUR_W-1:0]   poll_v, open_v, pass_v, enable_v, recheck_v, settle_v, half_v;
    logic [bgs_pkg::BLINK_W-1:0] blinks_v;
    poll_v    = bgs_pkg::DUR_W'($urandom_range(1, 3));
    open_v    = bgs_pkg::DUR_W'($urandom_range(0, 3));
    pass_v    = bgs_pkg::DUR_W'($urandom_range(0, 3));
    enable_v  = bgs_pkg::DUR_W'($urandom_range(0, 3));
    recheck_v = bgs_pkg::DUR_W'($urandom_range(0, 3));
    settle_v  = bgs_pkg::DUR_W'($urandom_range(0, 3));
    half_v    = bgs_pkg::DUR_W'($urandom_range(1, 2));
    blinks_v  = bgs_pkg::BLINK_W'($urandom_range(1, 3));
    case (kind)
      SET_MIN: begin
        poll_v = 16'd1;
        open_v = '0;
        pass_v = '0;
        enable_v = '0;
        recheck_v = '0;
        settle_v = '0;
        half_v = 16'd1;
        blinks_v = '0;
      end
      SET_BLINKS: begin
        half_v = 16'd1;
        blinks_v = '1;
      end
      SET_MAX: begin
        poll_v = '1;
        open_v = '1;
        pass_v = '1;
        enable_v = '1;
        recheck_v = '1;
        settle_v = '1;
        half_v = '1;
        blinks_v = '1;
      end
      default: ;
    endcase
    write_reg(bgs_pkg::CFG_POLL_PERIOD, poll_v);
    write_reg(bgs_pkg::CFG_OPEN_SETTLE, open_v);
    write_reg(bgs_pkg::CFG_PASS_WAIT, pass_v);
    write_reg(bgs_pkg::CFG_PROBE_ENABLE, enable_v);
    write_reg(bgs_pkg::CFG_PROBE_RECHECK, recheck_v);
    write_reg(bgs_pkg::CFG_CLOSE_SETTLE, settle_v);
    write_reg(bgs_pkg::CFG_BLINK_HALF, half_v);
    write_reg(bgs_pkg::CFG_BLINK_COUNT,
              {{(bgs_pkg::DUR_W-bgs_pkg::BLINK_W){1'b0}}, blinks_v});
  endtask

  initial begin
    gate_setting_t plan [8];
    int            plan_items [8];
    tick_pins_t    first;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    steady = 1'b0;
    tick_ch.valid = 1'b0;
    tick_ch.access_request = 1'b0;
    tick_ch.open_limit = 1'b0;
    tick_ch.light_clear = 1'b0;
    tick_ch.close_limit = 1'b0;
    res_ch.ready = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = bgs_pkg::CFG_POLL_PERIOD;
    cfg_ch.data = '0;
    plan = '{SET_SMALL, SET_MIN, SET_BLINKS, SET_SMALL, SET_MAX, SET_SMALL, SET_MIN,
             SET_SMALL};
    plan_items = '{90, 90, 90, 90, 30, 90, 90, 90};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Startup under reset settings: the seed picks closed-at-once or the close drive.
    first = '0;
    first.close_limit = 1'($urandom_range(0, 1));
    send_tick(first);
    run_ticks(10, 1'b0);
    wait_drained();

    // A short poll period written mid-wait ends a pending startup on the next tick.
    apply_setting(SET_MIN);
    run_ticks(14, 1'b0);
    wait_drained();

    for (int k = 0; k < 8; k++) begin
      apply_setting(plan[k]);
      steady = (k == 3);
      run_ticks(plan_items[k], 1'b1);
      wait_drained();
    end
    steady = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_400_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
